// File: hw/rtl/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;

    // Status fields are sized for the largest supported store (256 slots)
    localparam int SLOT_BITS  = 8;
    localparam int COUNT_BITS = 9;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_slot;
        logic [SLOT_BITS-1:0]  hit_rank;
        logic                  old_found;
        logic [SLOT_BITS-1:0]  old_slot;
        logic [SLOT_BITS-1:0]  old_rank;
        logic                  free_found;
        logic [SLOT_BITS-1:0]  free_slot;
        logic [COUNT_BITS-1:0] count;
    } t_scan_stat;

endpackage

// File: hw/rtl/lkv_req_if.sv
`timescale 1ns / 1ps

interface lkv_req_if import lkv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// File: hw/rtl/lkv_rsp_if.sv
`timescale 1ns / 1ps

interface lkv_rsp_if import lkv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// File: hw/rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// A get returns hit and the stored value (zero on a miss) and makes the entry
// most recent; a put updates or inserts and returns nothing. Keys, values and
// recency ranks sit in single-write, registered-read memories, and one slot
// compare unit walks them a slot per cycle. One sweep over the key and rank
// memories finds the match, the oldest entry and a free slot; a put and a get
// that hits then make a second sweep that rewrites every rank through the
// same memory port, and a get that misses skips it. A finished get waits in
// the output register until taken. Capacity 0 behaves as 1 and values above
// ENTRIES as ENTRIES; the store is empty after reset.
module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CAP_BITS-1:0] i_cfg_wr_data,
    lkv_req_if.sink             i_req,
    lkv_rsp_if.source           o_rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = $clog2(ENTRIES + 1);
    localparam int MW = (IW > CAP_BITS) ? IW : CAP_BITS;
    localparam logic [MW-1:0] ENTRIES_M = MW'(ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]            r_state,    n_state;
    logic [IW-1:0]         r_idx,      n_idx;
    logic                  r_op,       n_op;
    logic [KEY_BITS-1:0]   r_key,      n_key;
    logic [VALUE_BITS-1:0] r_val,      n_val;
    logic [AW-1:0]         r_tgt,      n_tgt;
    logic [AW-1:0]         r_thr,      n_thr;
    logic                  r_age_all,  n_age_all;
    logic [ENTRIES-1:0]    r_valid,    n_valid;
    logic [CAP_BITS-1:0]   r_capacity;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit,   n_out_hit;
    logic [VALUE_BITS-1:0] r_out_val,   n_out_val;

    logic [IW-1:0]         idx_dec;
    logic [AW-1:0]         slot_prev;
    logic                  last;
    logic [MW-1:0]         cap_m;
    logic [MW-1:0]         cap_eff;
    logic [MW-1:0]         cnt_m;
    logic                  do_fill;

    t_scan_ctl             scan_ctl;
    t_scan_stat            stat;
    logic [AW-1:0]         new_rank;

    logic                  key_we;
    logic [AW-1:0]         key_wa;
    logic [KEY_BITS-1:0]   key_rd;
    logic                  val_we;
    logic [AW-1:0]         val_wa;
    logic [VALUE_BITS-1:0] val_rd;
    logic                  rank_we;
    logic [AW-1:0]         rank_rd;

    assign idx_dec   = r_idx - IW'(1);
    assign slot_prev = idx_dec[AW-1:0];
    assign last      = (r_idx == IW'(ENTRIES));

    assign cap_m = MW'(r_capacity);
    assign cnt_m = MW'(stat.count);
    always_comb begin
        if (cap_m == '0) begin
            cap_eff = MW'(1);
        end else if (cap_m > ENTRIES_M) begin
            cap_eff = ENTRIES_M;
        end else begin
            cap_eff = cap_m;
        end
    end
    assign do_fill = (cnt_m < cap_eff) && stat.free_found;

    assign scan_ctl.clear  = (r_state == S_IDLE) && i_req.valid;
    assign scan_ctl.sample = (r_state == S_SCAN) && (r_idx != '0);

    lkv_slot_unit #(
        .ENTRIES (ENTRIES)
    ) u_slot_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_slot     (slot_prev),
        .i_valid    (r_valid[slot_prev]),
        .i_key      (r_key),
        .i_rd_key   (key_rd),
        .i_rd_rank  (rank_rd),
        .i_tgt      (r_tgt),
        .i_thr      (r_thr),
        .i_age_all  (r_age_all),
        .o_stat     (stat),
        .o_new_rank (new_rank)
    );

    lkv_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (key_wa),
        .i_wr_data (r_key),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (key_rd)
    );

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_wa),
        .i_wr_data (r_val),
        .i_rd_addr (stat.hit_slot[AW-1:0]),
        .o_rd_data (val_rd)
    );

    lkv_ram #(
        .WIDTH (AW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rank_we),
        .i_wr_addr (slot_prev),
        .i_wr_data (new_rank),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rank_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_tgt       = r_tgt;
        n_thr       = r_thr;
        n_age_all   = r_age_all;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_hit   = r_out_hit;
        n_out_val   = r_out_val;
        key_we      = 1'b0;
        key_wa      = stat.free_slot[AW-1:0];
        val_we      = 1'b0;
        val_wa      = stat.hit_slot[AW-1:0];
        rank_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_key   = i_req.key;
                    n_val   = i_req.value;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx     = '0;
                n_age_all = 1'b0;
                n_tgt     = stat.hit_slot[AW-1:0];
                n_thr     = stat.hit_rank[AW-1:0];
                n_state   = S_UPD;
                if (r_op == OP_GET) begin
                    if (!stat.hit) begin
                        n_state = S_RESULT;
                    end
                end else if (stat.hit) begin
                    val_we = 1'b1;
                end else if (do_fill) begin
                    // new entry is youngest, every valid entry ages
                    key_we    = 1'b1;
                    val_we    = 1'b1;
                    val_wa    = stat.free_slot[AW-1:0];
                    n_valid[stat.free_slot[AW-1:0]] = 1'b1;
                    n_tgt     = stat.free_slot[AW-1:0];
                    n_age_all = 1'b1;
                end else begin
                    // evict the least recent entry in place
                    key_we = 1'b1;
                    key_wa = stat.old_slot[AW-1:0];
                    val_we = 1'b1;
                    val_wa = stat.old_slot[AW-1:0];
                    n_tgt  = stat.old_slot[AW-1:0];
                    n_thr  = stat.old_rank[AW-1:0];
                end
            end
            S_UPD: begin
                n_idx   = r_idx + IW'(1);
                rank_we = (r_idx != '0);
                if (last) begin
                    n_state = (r_op == OP_PUT) ? S_IDLE : S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = stat.hit;
                    n_out_val   = stat.hit ? val_rd : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_capacity  <= CAP_BITS'(16);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_tgt     <= n_tgt;
        r_thr     <= n_thr;
        r_age_all <= n_age_all;
        r_out_hit <= n_out_hit;
        r_out_val <= n_out_val;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_val;

endmodule

// File: hw/rtl/lkv_ram.sv
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/lkv_slot_unit.sv
`timescale 1ns / 1ps

module lkv_slot_unit import lkv_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  t_scan_ctl                                    i_ctl,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_slot,
    input  logic                                         i_valid,
    input  logic [KEY_BITS-1:0]                          i_key,
    input  logic [KEY_BITS-1:0]                          i_rd_key,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_rd_rank,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_tgt,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_thr,
    input  logic                                         i_age_all,
    output t_scan_stat                                   o_stat,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_new_rank
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = $clog2(ENTRIES + 1);

    logic          r_hit,        n_hit;
    logic [AW-1:0] r_hit_slot,   n_hit_slot;
    logic [AW-1:0] r_hit_rank,   n_hit_rank;
    logic          r_old_found,  n_old_found;
    logic [AW-1:0] r_old_slot,   n_old_slot;
    logic [AW-1:0] r_old_rank,   n_old_rank;
    logic          r_free_found, n_free_found;
    logic [AW-1:0] r_free_slot,  n_free_slot;
    logic [IW-1:0] r_count,      n_count;
    logic          key_match;

    assign key_match = i_valid && (i_rd_key == i_key);

    always_comb begin
        n_hit        = r_hit;
        n_hit_slot   = r_hit_slot;
        n_hit_rank   = r_hit_rank;
        n_old_found  = r_old_found;
        n_old_slot   = r_old_slot;
        n_old_rank   = r_old_rank;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_count      = r_count;
        if (i_ctl.clear) begin
            n_hit        = 1'b0;
            n_old_found  = 1'b0;
            n_free_found = 1'b0;
            n_count      = '0;
        end else if (i_ctl.sample) begin
            // keep the first matching slot
            if (key_match && !r_hit) begin
                n_hit      = 1'b1;
                n_hit_slot = i_slot;
                n_hit_rank = i_rd_rank;
            end
            if (i_valid) begin
                n_count = r_count + IW'(1);
                if (!r_old_found || (i_rd_rank > r_old_rank)) begin
                    n_old_found = 1'b1;
                    n_old_slot  = i_slot;
                    n_old_rank  = i_rd_rank;
                end
            end else if (!r_free_found) begin
                n_free_found = 1'b1;
                n_free_slot  = i_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_old_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
        end else begin
            r_hit        <= n_hit;
            r_old_found  <= n_old_found;
            r_free_found <= n_free_found;
            r_count      <= n_count;
        end
        r_hit_slot  <= n_hit_slot;
        r_hit_rank  <= n_hit_rank;
        r_old_slot  <= n_old_slot;
        r_old_rank  <= n_old_rank;
        r_free_slot <= n_free_slot;
    end

    // Target slot becomes most recent; other valid slots age when younger than the threshold or when all age
    always_comb begin
        if (i_slot == i_tgt) begin
            o_new_rank = '0;
        end else if (i_valid && (i_age_all || (i_rd_rank < i_thr))) begin
            o_new_rank = i_rd_rank + AW'(1);
        end else begin
            o_new_rank = i_rd_rank;
        end
    end

    assign o_stat.hit        = r_hit;
    assign o_stat.hit_slot   = SLOT_BITS'(r_hit_slot);
    assign o_stat.hit_rank   = SLOT_BITS'(r_hit_rank);
    assign o_stat.old_found  = r_old_found;
    assign o_stat.old_slot   = SLOT_BITS'(r_old_slot);
    assign o_stat.old_rank   = SLOT_BITS'(r_old_rank);
    assign o_stat.free_found = r_free_found;
    assign o_stat.free_slot  = SLOT_BITS'(r_free_slot);
    assign o_stat.count      = COUNT_BITS'(r_count);

endmodule
